// ===== src/ccsv_pkg.sv =====
// Shared types, constants and the parameter-count ROM for the chart command
// stream validator. No dependencies; every other file imports this package.
package ccsv_pkg;

   // Port widths
   localparam int REQ_TDATA_W = 64;   // word, start_offset
   localparam int RSP_TDATA_W = 136;  // result fields, padded to whole bytes
   localparam int RSP_TUSER_W = 2;    // accepted, new_best
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // Field widths
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 18;
   localparam int TIME_W   = 31;
   localparam int TTYPE_W  = 8;
   localparam int BYTES_W  = 24;
   localparam int SCORE_W  = 25;
   localparam int OFFSET_W = 32;
   localparam int PCOUNT_W = 5;
   localparam int OPIDX_W  = 7;

   localparam int OPCODE_COUNT = 107;
   localparam logic [BYTES_W:0] MAX_CANDIDATE_BYTES = 25'd12582912;

   // Opcodes
   localparam logic [WORD_W-1:0] OP_END         = 32'h00;
   localparam logic [WORD_W-1:0] OP_TIME        = 32'h01;
   localparam logic [WORD_W-1:0] OP_TARGET      = 32'h06;
   localparam logic [WORD_W-1:0] OP_MODE_SELECT = 32'h1A;
   localparam logic [WORD_W-1:0] OP_FLYING_A    = 32'h1C;
   localparam logic [WORD_W-1:0] OP_FLYING_B    = 32'h3A;
   localparam logic [WORD_W-1:0] OP_LAST        = 32'h6A;

   // Score weights
   localparam logic [6:0] W_COMMAND     = 7'd1;
   localparam logic [6:0] W_TIME        = 7'd8;
   localparam logic [6:0] W_TARGET      = 7'd100;
   localparam logic [6:0] W_MODE_SELECT = 7'd20;
   localparam logic [6:0] W_FLYING      = 7'd5;

   // Parameter words that follow each opcode
   localparam logic [PCOUNT_W-1:0] PARAM_TABLE [OPCODE_COUNT] = '{
      5'd0, 5'd1, 5'd4, 5'd2, 5'd2, 5'd2, 5'd7, 5'd4,
      5'd2, 5'd6, 5'd2, 5'd1, 5'd6, 5'd2, 5'd1, 5'd1,
      5'd3, 5'd2, 5'd3, 5'd5, 5'd5, 5'd4, 5'd4, 5'd5,
      5'd2, 5'd0, 5'd2, 5'd4, 5'd2, 5'd2, 5'd1, 5'd21,
      5'd0, 5'd3, 5'd2, 5'd5, 5'd1, 5'd1, 5'd7, 5'd1,
      5'd1, 5'd2, 5'd1, 5'd2, 5'd1, 5'd2, 5'd3, 5'd3,
      5'd1, 5'd2, 5'd2, 5'd3, 5'd6, 5'd6, 5'd1, 5'd1,
      5'd2, 5'd3, 5'd1, 5'd2, 5'd2, 5'd4, 5'd4, 5'd1,
      5'd2, 5'd1, 5'd2, 5'd1, 5'd1, 5'd3, 5'd3, 5'd3,
      5'd2, 5'd1, 5'd9, 5'd3, 5'd2, 5'd4, 5'd2, 5'd3,
      5'd2, 5'd24, 5'd1, 5'd2, 5'd1, 5'd3, 5'd1, 5'd3,
      5'd4, 5'd1, 5'd2, 5'd6, 5'd3, 5'd2, 5'd3, 5'd3,
      5'd4, 5'd1, 5'd1, 5'd3, 5'd3, 5'd4, 5'd2, 5'd3,
      5'd3, 5'd8, 5'd2
   };

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_COMMANDS    = 3'd0,
      CSR_MIN_TIMES       = 3'd1,
      CSR_MIN_TARGETS     = 3'd2,
      CSR_MAX_TIME        = 3'd3,
      CSR_MAX_TARGET_TYPE = 3'd4,
      CSR_MAX_COMMANDS    = 3'd5
   } ccsv_csr_type;

   // Register reset values
   localparam logic [COUNT_W-1:0] RST_MIN_COMMANDS    = 18'd40;
   localparam logic [COUNT_W-1:0] RST_MIN_TIMES       = 18'd8;
   localparam logic [COUNT_W-1:0] RST_MIN_TARGETS     = 18'd16;
   localparam logic [TIME_W-1:0]  RST_MAX_TIME        = 31'd720000000;
   localparam logic [TTYPE_W-1:0] RST_MAX_TARGET_TYPE = 8'd31;
   localparam logic [COUNT_W-1:0] RST_MAX_COMMANDS    = 18'd250000;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_OPCODE = 2'd1,
      PH_PARAMS = 2'd2
   } ccsv_phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0] min_commands;
      logic [COUNT_W-1:0] min_times;
      logic [COUNT_W-1:0] min_targets;
      logic [TIME_W-1:0]  max_time;
      logic [TTYPE_W-1:0] max_target_type;
      logic [COUNT_W-1:0] max_commands;
   } ccsv_cfg_type;

   typedef struct packed {
      logic                valid;
      logic                accepted;
      logic                new_best;
      logic [SCORE_W-1:0]  score;
      logic [BYTES_W-1:0]  length_bytes;
      logic [COUNT_W-1:0]  command_count;
      logic [COUNT_W-1:0]  time_count;
      logic [COUNT_W-1:0]  target_count;
      logic [OFFSET_W-1:0] offset_out;
   } ccsv_result_type;

endpackage

// ===== src/ccsv_parser.sv =====
// Per-word parse step: candidate state, checks, score and best tracking.
// Depends on ccsv_pkg.
module ccsv_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [ccsv_pkg::WORD_W-1:0] word,
   input  logic                        first,
   input  logic [ccsv_pkg::OFFSET_W-1:0] start_offset,
   input  logic                        end_of_data,
   input  ccsv_pkg::ccsv_cfg_type      cfg,
   output ccsv_pkg::ccsv_result_type   result
);
   import ccsv_pkg::*;

   ccsv_phase_type      phase_ff, phase_in, e_phase;
   logic [PCOUNT_W-1:0] params_left_ff, params_left_in, e_params, params_dec;
   logic [OPIDX_W-1:0]  cur_op_ff, cur_op_in, e_cur_op;
   logic                at_first_ff, at_first_in, e_at_first;
   logic [TIME_W-1:0]   last_time_ff, last_time_in, e_last_time;
   logic [COUNT_W-1:0]  cmd_ff, cmd_in, e_cmd;
   logic [COUNT_W-1:0]  time_ff, time_in, e_time;
   logic [COUNT_W-1:0]  tgt_ff, tgt_in, e_tgt;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in, e_bytes;
   logic [SCORE_W-1:0]  score_ff, score_in, e_score;
   logic [OFFSET_W-1:0] offset_ff, offset_in, e_offset;
   logic                best_valid_ff;
   logic [SCORE_W-1:0]  best_score_ff;
   logic [BYTES_W-1:0]  best_length_ff;

   logic [PCOUNT_W-1:0] tbl_p;
   logic [BYTES_W:0]    bytes_plus4, span_end;
   logic [6:0]          op_weight;
   logic                is_time_op, is_target_op, time_bad;
   logic                reject, finish, meets, accept, better;

   // Candidate state as seen by this word: a first word starts from clear
   always_comb begin
      if (first) begin
         e_phase     = PH_OPCODE;
         e_params    = '0;
         e_cur_op    = '0;
         e_at_first  = 1'b0;
         e_last_time = '0;
         e_cmd       = '0;
         e_time      = '0;
         e_tgt       = '0;
         e_bytes     = '0;
         e_score     = '0;
         e_offset    = start_offset;
      end else begin
         e_phase     = phase_ff;
         e_params    = params_left_ff;
         e_cur_op    = cur_op_ff;
         e_at_first  = at_first_ff;
         e_last_time = last_time_ff;
         e_cmd       = cmd_ff;
         e_time      = time_ff;
         e_tgt       = tgt_ff;
         e_bytes     = bytes_ff;
         e_score     = score_ff;
         e_offset    = offset_ff;
      end
   end

   assign tbl_p       = PARAM_TABLE[word[OPIDX_W-1:0]];
   assign bytes_plus4 = {1'b0, e_bytes} + 25'd4;
   assign span_end    = bytes_plus4 + {18'd0, tbl_p, 2'b00};
   assign params_dec  = (e_params != '0) ? e_params - 5'd1 : '0;
   assign is_time_op  = ({25'd0, e_cur_op} == OP_TIME);
   assign is_target_op = ({25'd0, e_cur_op} == OP_TARGET);
   assign time_bad    = word[WORD_W-1] || (word[TIME_W-1:0] < e_last_time) ||
                        (word[TIME_W-1:0] > cfg.max_time);

   always_comb begin
      if (word == OP_MODE_SELECT) begin
         op_weight = W_COMMAND + W_MODE_SELECT;
      end else if (word == OP_FLYING_A || word == OP_FLYING_B) begin
         op_weight = W_COMMAND + W_FLYING;
      end else begin
         op_weight = W_COMMAND;
      end
   end

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      params_left_in = params_left_ff;
      cur_op_in      = cur_op_ff;
      at_first_in    = at_first_ff;
      last_time_in   = last_time_ff;
      cmd_in         = cmd_ff;
      time_in        = time_ff;
      tgt_in         = tgt_ff;
      bytes_in       = bytes_ff;
      score_in       = score_ff;
      offset_in      = offset_ff;
      reject         = 1'b0;
      finish         = 1'b0;
      if (go) begin
         phase_in       = e_phase;
         params_left_in = e_params;
         cur_op_in      = e_cur_op;
         at_first_in    = e_at_first;
         last_time_in   = e_last_time;
         cmd_in         = e_cmd;
         time_in        = e_time;
         tgt_in         = e_tgt;
         bytes_in       = e_bytes;
         score_in       = e_score;
         offset_in      = e_offset;
         if (first && word != OP_TIME) begin
            reject = 1'b1;
         end else if (e_phase == PH_OPCODE) begin
            if (e_cmd >= cfg.max_commands) begin
               reject = 1'b1;
            end else if (bytes_plus4 > MAX_CANDIDATE_BYTES) begin
               reject = 1'b1;
            end else if (word > OP_LAST) begin
               reject = 1'b1;
            end else if (word == OP_END) begin
               finish   = 1'b1;
               cmd_in   = e_cmd + 18'd1;
               bytes_in = bytes_plus4[BYTES_W-1:0];
               score_in = e_score + {18'd0, W_COMMAND};
            end else if (span_end > MAX_CANDIDATE_BYTES) begin
               reject = 1'b1;
            end else begin
               cmd_in    = e_cmd + 18'd1;
               bytes_in  = bytes_plus4[BYTES_W-1:0];
               score_in  = e_score + {18'd0, op_weight};
               cur_op_in = word[OPIDX_W-1:0];
               if (tbl_p != '0) begin
                  params_left_in = tbl_p;
                  at_first_in    = 1'b1;
                  phase_in       = PH_PARAMS;
               end
            end
         end else if (e_phase == PH_PARAMS) begin
            bytes_in = bytes_plus4[BYTES_W-1:0];
            if (e_at_first && is_time_op) begin
               if (time_bad) begin
                  reject = 1'b1;
               end else begin
                  last_time_in = word[TIME_W-1:0];
                  time_in      = e_time + 18'd1;
                  score_in     = e_score + {18'd0, W_TIME};
               end
            end else if (e_at_first && is_target_op) begin
               if (word > {24'd0, cfg.max_target_type}) begin
                  reject = 1'b1;
               end else begin
                  tgt_in   = e_tgt + 18'd1;
                  score_in = e_score + {18'd0, W_TARGET};
               end
            end
            at_first_in    = 1'b0;
            params_left_in = params_dec;
            if (params_dec == '0) begin
               phase_in = PH_OPCODE;
            end
         end
         // Truncated: candidate still open on the last buffer word
         if (e_phase != PH_IDLE && !finish && end_of_data) begin
            reject = 1'b1;
         end
         if (reject || finish) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Result and best-candidate decision
   always_comb begin
      meets  = (cmd_in >= cfg.min_commands) && (time_in >= cfg.min_times) &&
               (tgt_in >= cfg.min_targets);
      accept = finish && meets;
      better = !best_valid_ff || (score_in > best_score_ff) ||
               (score_in == best_score_ff && bytes_in > best_length_ff);
      result.valid         = reject || finish;
      result.accepted      = accept;
      result.new_best      = accept && better;
      result.score         = accept ? score_in : '0;
      result.length_bytes  = accept ? bytes_in : '0;
      result.command_count = accept ? cmd_in : '0;
      result.time_count    = accept ? time_in : '0;
      result.target_count  = accept ? tgt_in : '0;
      result.offset_out    = offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         params_left_ff <= '0;
         cur_op_ff      <= '0;
         at_first_ff    <= 1'b0;
         last_time_ff   <= '0;
         cmd_ff         <= '0;
         time_ff        <= '0;
         tgt_ff         <= '0;
         bytes_ff       <= '0;
         score_ff       <= '0;
         offset_ff      <= '0;
         best_valid_ff  <= 1'b0;
         best_score_ff  <= '0;
         best_length_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         params_left_ff <= params_left_in;
         cur_op_ff      <= cur_op_in;
         at_first_ff    <= at_first_in;
         last_time_ff   <= last_time_in;
         cmd_ff         <= cmd_in;
         time_ff        <= time_in;
         tgt_ff         <= tgt_in;
         bytes_ff       <= bytes_in;
         score_ff       <= score_in;
         offset_ff      <= offset_in;
         if (accept && better) begin
            best_valid_ff  <= 1'b1;
            best_score_ff  <= score_in;
            best_length_ff <= bytes_in;
         end
      end
   end

endmodule

// ===== src/chart_command_stream_validator.sv =====
// Top level of the chart command stream validator: input register, parse step,
// result register and configuration registers. Depends on ccsv_pkg, ccsv_parser.
// A result transaction passes the input register and then the result register before it shows on rsp_tvalid.
// Throughput: one word per cycle while the result stream does not stall, set by the parse step and its state.
// Reset (synchronous): parser idle, best candidate cleared, registers to defaults.
module chart_command_stream_validator (
   input  logic                             clock,
   input  logic                             reset,
   // Input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ccsv_pkg::REQ_TDATA_W-1:0] req_tdata,  // word[31:0], start_offset[63:32]
   input  logic                             req_tuser,  // first
   input  logic                             req_tlast,  // end_of_data
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // score[24:0], length_bytes[48:25], command_count[66:49], time_count[84:67],
   // target_count[102:85], offset_out[134:103], zero pad[135]
   output logic [ccsv_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [ccsv_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // accepted[0], new_best[1]
   // Configuration writes
   input  logic                             csr_we,
   input  logic [ccsv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccsv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ccsv_pkg::*;

   // Input register stage
   logic                s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0]   s1_word_ff;
   logic                s1_first_ff;
   logic [OFFSET_W-1:0] s1_offset_ff;
   logic                s1_eod_ff;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   ccsv_result_type     rsp_ff;
   ccsv_result_type     step_result;

   ccsv_cfg_type        cfg_ff;

   logic                advance;
   logic                go;
   logic                req_take;

   // The result register frees up when empty or when its transaction is taken;
   // the input register moves on whenever the result register can advance.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign go         = s1_valid_ff && advance;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? (go && step_result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the incoming word; payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff   <= req_tdata[WORD_W-1:0];
         s1_offset_ff <= req_tdata[WORD_W +: OFFSET_W];
         s1_first_ff  <= req_tuser;
         s1_eod_ff    <= req_tlast;
      end
   end

   // Hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   // Configuration registers; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_commands    <= RST_MIN_COMMANDS;
         cfg_ff.min_times       <= RST_MIN_TIMES;
         cfg_ff.min_targets     <= RST_MIN_TARGETS;
         cfg_ff.max_time        <= RST_MAX_TIME;
         cfg_ff.max_target_type <= RST_MAX_TARGET_TYPE;
         cfg_ff.max_commands    <= RST_MAX_COMMANDS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_COMMANDS:    cfg_ff.min_commands    <= csr_wdata[COUNT_W-1:0];
            CSR_MIN_TIMES:       cfg_ff.min_times       <= csr_wdata[COUNT_W-1:0];
            CSR_MIN_TARGETS:     cfg_ff.min_targets     <= csr_wdata[COUNT_W-1:0];
            CSR_MAX_TIME:        cfg_ff.max_time        <= csr_wdata[TIME_W-1:0];
            CSR_MAX_TARGET_TYPE: cfg_ff.max_target_type <= csr_wdata[TTYPE_W-1:0];
            CSR_MAX_COMMANDS:    cfg_ff.max_commands    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Parse one word per cycle, while the result register can advance, against the open candidate
   ccsv_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .word         (s1_word_ff),
      .first        (s1_first_ff),
      .start_offset (s1_offset_ff),
      .end_of_data  (s1_eod_ff),
      .cfg          (cfg_ff),
      .result       (step_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.offset_out, rsp_ff.target_count, rsp_ff.time_count,
                        rsp_ff.command_count, rsp_ff.length_bytes, rsp_ff.score};
   assign rsp_tuser  = {rsp_ff.new_best, rsp_ff.accepted};

   // A new best must be an accepted candidate
   a_best_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.accepted || !rsp_ff.new_best))
      else $error("new_best set on a rejected candidate");

   // Rejected transactions carry no score or counts
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |->
         (rsp_ff.score == '0 && rsp_ff.command_count == '0 &&
          rsp_ff.length_bytes == '0))
      else $error("rejected result with nonzero fields");

   // Every command adds at least one to the score, and time and target
   // commands are a subset of all commands
   a_score_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accepted) |->
         ({7'd0, rsp_ff.command_count} <= rsp_ff.score &&
          {1'b0, rsp_ff.time_count} + {1'b0, rsp_ff.target_count} <=
          {1'b0, rsp_ff.command_count}))
      else $error("score or counts inconsistent");

   // A stalled result freezes the input register
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("input register moved during result stall");

endmodule
